// ----- src/shader_source_tokenizer_assert.svh -----
// Assertion macros used by the tokenizer RTL (sst_emit).
// Expects clk and rst_n in the including module's scope.
`ifndef SHADER_SOURCE_TOKENIZER_ASSERT_SVH
`define SHADER_SOURCE_TOKENIZER_ASSERT_SVH

// same-cycle implication
`define SST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/sst_pkg.sv -----
// Shared types and constants for the shader source tokenizer.
// No dependencies.
package sst_pkg;

  localparam int MAX_RES     = 4;
  localparam int CNT_W       = $clog2(MAX_RES + 1);
  localparam int IDX_W       = $clog2(MAX_RES);
  localparam int QUEUE_DEPTH = 4;
  localparam int TDATA_W     = 48;
  localparam int TUSER_W     = 4;

  localparam logic       KIND_TEXT = 1'b0;
  localparam logic       KIND_END  = 1'b1;

  localparam logic [2:0] TOK_IDENT   = 3'd0;
  localparam logic [2:0] TOK_NUMBER  = 3'd1;
  localparam logic [2:0] TOK_STRING  = 3'd2;
  localparam logic [2:0] TOK_OPER    = 3'd3;
  localparam logic [2:0] TOK_NEWLINE = 3'd4;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_DOT     = 2'd1;
  localparam logic [1:0] ERR_ESCAPE  = 2'd2;
  localparam logic [1:0] ERR_UNTERM  = 2'd3;

  typedef struct packed {
    logic       kind;
    logic [2:0] ttype;
    logic [7:0] data;
    logic [1:0] err;
  } res_t;

  // all results caused by one input byte
  typedef struct packed {
    logic [CNT_W-1:0]        cnt;
    logic [15:0]             line;
    logic [15:0]             col;
    res_t [MAX_RES-1:0]      res;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- src/sst_lexer.sv -----
// Front end: accepts source bytes, runs the lexer state, builds result bundles.
// Depends on sst_pkg.
module sst_lexer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  sst_pkg::q_stat_t  q_stat,
  output logic              push,
  output sst_pkg::bundle_t  bundle
);

  typedef enum logic [3:0] {
    M_IDLE       = 4'd0,
    M_IDENT      = 4'd1,
    M_NUMBER     = 4'd2,
    M_STRING     = 4'd3,
    M_STR_ESC    = 4'd4,
    M_SLASH      = 4'd5,
    M_LINE_CMT   = 4'd6,
    M_BLOCK_CMT  = 4'd7,
    M_BLOCK_STAR = 4'd8
  } mode_t;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  mode_t       mode_r, mode_nxt;
  logic        dot_r, dot_nxt;
  logic [15:0] line_r, line_nxt;
  logic [15:0] col_r, col_nxt;
  logic [15:0] line_pos, col_pos;
  logic        acc;
  logic        run_idle;
  logic [8:0]  esc;
  sst_pkg::bundle_t b;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c inside {[8'h61:8'h7A]}) || (c inside {[8'h41:8'h5A]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  // {known, value}
  function automatic logic [8:0] escape_value(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      CH_BSL, CH_SLASH, CH_QUOTE: r = {1'b1, c};
      8'h62:   r = {1'b1, 8'h08};
      8'h66:   r = {1'b1, 8'h0C};
      8'h6E:   r = {1'b1, 8'h0A};
      8'h72:   r = {1'b1, 8'h0D};
      8'h74:   r = {1'b1, 8'h09};
      default: r = {1'b0, c};
    endcase
    return r;
  endfunction

  function automatic sst_pkg::bundle_t add_res(input sst_pkg::bundle_t bi, input logic kind,
                                               input logic [2:0] tt, input logic [7:0] d,
                                               input logic [1:0] e);
    sst_pkg::bundle_t bo;
    bo = bi;
    if (bi.cnt < sst_pkg::CNT_W'(sst_pkg::MAX_RES)) begin
      bo.res[bi.cnt[sst_pkg::IDX_W-1:0]] = '{kind, tt, d, e};
      bo.cnt = bi.cnt + 1'b1;
    end
    return bo;
  endfunction

  assign in_tready = !q_stat.full;
  assign acc       = in_tvalid && in_tready;
  assign push      = acc && (b.cnt != '0);
  assign bundle    = b;
  assign esc       = escape_value(in_byte);

  always_comb begin
    if (in_byte == CH_LF) begin
      line_pos = (line_r != 16'hFFFF) ? line_r + 16'd1 : line_r;
      col_pos  = 16'd0;
    end else begin
      line_pos = line_r;
      col_pos  = (col_r != 16'hFFFF) ? col_r + 16'd1 : col_r;
    end
  end

  always_comb begin
    b        = '0;
    b.line   = line_pos;
    b.col    = col_pos;
    mode_nxt = mode_r;
    dot_nxt  = dot_r;
    line_nxt = line_pos;
    col_nxt  = col_pos;
    run_idle = 1'b0;

    case (mode_r)
      M_IDENT: begin
        if (in_byte == CH_UNDER || is_alpha(in_byte) || is_digit(in_byte)) begin
          b = add_res(b, sst_pkg::KIND_TEXT, sst_pkg::TOK_IDENT, in_byte, sst_pkg::ERR_NONE);
        end else begin
          b = add_res(b, sst_pkg::KIND_END, sst_pkg::TOK_IDENT, 8'h00, sst_pkg::ERR_NONE);
          mode_nxt = M_IDLE;
          run_idle = 1'b1;
        end
      end
      M_NUMBER: begin
        if (in_byte == CH_DOT) begin
          b = add_res(b, sst_pkg::KIND_TEXT, sst_pkg::TOK_NUMBER, in_byte,
                      dot_r ? sst_pkg::ERR_DOT : sst_pkg::ERR_NONE);
          dot_nxt = 1'b1;
        end else if (is_digit(in_byte)) begin
          b = add_res(b, sst_pkg::KIND_TEXT, sst_pkg::TOK_NUMBER, in_byte, sst_pkg::ERR_NONE);
        end else begin
          b = add_res(b, sst_pkg::KIND_END, sst_pkg::TOK_NUMBER, 8'h00, sst_pkg::ERR_NONE);
          mode_nxt = M_IDLE;
          run_idle = 1'b1;
        end
      end
      M_STRING: begin
        if (in_byte == CH_BSL) begin
          mode_nxt = M_STR_ESC;
        end else if (in_byte == CH_QUOTE) begin
          b = add_res(b, sst_pkg::KIND_END, sst_pkg::TOK_STRING, 8'h00, sst_pkg::ERR_NONE);
          mode_nxt = M_IDLE;
        end else begin
          b = add_res(b, sst_pkg::KIND_TEXT, sst_pkg::TOK_STRING, in_byte, sst_pkg::ERR_NONE);
        end
      end
      M_STR_ESC: begin
        b = add_res(b, sst_pkg::KIND_TEXT, sst_pkg::TOK_STRING, esc[7:0],
                    esc[8] ? sst_pkg::ERR_NONE : sst_pkg::ERR_ESCAPE);
        mode_nxt = M_STRING;
      end
      M_SLASH: begin
        if (in_byte == CH_STAR) begin
          mode_nxt = M_BLOCK_CMT;
        end else if (in_byte == CH_SLASH) begin
          mode_nxt = M_LINE_CMT;
        end else begin
          b = add_res(b, sst_pkg::KIND_TEXT, sst_pkg::TOK_OPER, CH_SLASH, sst_pkg::ERR_NONE);
          b = add_res(b, sst_pkg::KIND_END, sst_pkg::TOK_OPER, 8'h00, sst_pkg::ERR_NONE);
          mode_nxt = M_IDLE;
          run_idle = 1'b1;
        end
      end
      M_LINE_CMT: begin
        if (in_byte == CH_LF) mode_nxt = M_IDLE;
      end
      M_BLOCK_CMT: begin
        if (in_byte == CH_STAR) mode_nxt = M_BLOCK_STAR;
      end
      M_BLOCK_STAR: begin
        if (in_byte == CH_SLASH) mode_nxt = M_IDLE;
        else if (in_byte != CH_STAR) mode_nxt = M_BLOCK_CMT;
      end
      default: begin
        mode_nxt = M_IDLE;
        run_idle = 1'b1;
      end
    endcase

    if (run_idle) begin
      if (in_byte == CH_SPACE || in_byte == CH_TAB || in_byte == CH_CR) begin
        mode_nxt = M_IDLE;
      end else if (in_byte == CH_HASH) begin
        mode_nxt = M_LINE_CMT;
      end else if (in_byte == CH_UNDER || is_alpha(in_byte)) begin
        b = add_res(b, sst_pkg::KIND_TEXT, sst_pkg::TOK_IDENT, in_byte, sst_pkg::ERR_NONE);
        mode_nxt = M_IDENT;
      end else if (is_digit(in_byte)) begin
        b = add_res(b, sst_pkg::KIND_TEXT, sst_pkg::TOK_NUMBER, in_byte, sst_pkg::ERR_NONE);
        dot_nxt  = 1'b0;
        mode_nxt = M_NUMBER;
      end else if (in_byte == CH_QUOTE) begin
        mode_nxt = M_STRING;
      end else if (in_byte == CH_LF) begin
        b = add_res(b, sst_pkg::KIND_END, sst_pkg::TOK_NEWLINE, 8'h00, sst_pkg::ERR_NONE);
      end else if (in_byte == CH_SLASH) begin
        mode_nxt = M_SLASH;
      end else begin
        b = add_res(b, sst_pkg::KIND_TEXT, sst_pkg::TOK_OPER, in_byte, sst_pkg::ERR_NONE);
        b = add_res(b, sst_pkg::KIND_END, sst_pkg::TOK_OPER, 8'h00, sst_pkg::ERR_NONE);
      end
    end

    if (in_last) begin
      case (mode_nxt)
        M_IDENT:
          b = add_res(b, sst_pkg::KIND_END, sst_pkg::TOK_IDENT, 8'h00, sst_pkg::ERR_NONE);
        M_NUMBER:
          b = add_res(b, sst_pkg::KIND_END, sst_pkg::TOK_NUMBER, 8'h00, sst_pkg::ERR_NONE);
        M_SLASH: begin
          b = add_res(b, sst_pkg::KIND_TEXT, sst_pkg::TOK_OPER, CH_SLASH, sst_pkg::ERR_NONE);
          b = add_res(b, sst_pkg::KIND_END, sst_pkg::TOK_OPER, 8'h00, sst_pkg::ERR_NONE);
        end
        M_STRING, M_STR_ESC:
          b = add_res(b, sst_pkg::KIND_END, sst_pkg::TOK_STRING, 8'h00, sst_pkg::ERR_UNTERM);
        M_BLOCK_CMT, M_BLOCK_STAR:
          b = add_res(b, sst_pkg::KIND_END, sst_pkg::TOK_IDENT, 8'h00, sst_pkg::ERR_UNTERM);
        default: ;
      endcase
      mode_nxt = M_IDLE;
      dot_nxt  = 1'b0;
      line_nxt = 16'd1;
      col_nxt  = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      dot_r  <= 1'b0;
      line_r <= 16'd1;
      col_r  <= 16'd0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      dot_r  <= dot_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
    end
  end

endmodule

// ----- src/sst_fifo.sv -----
// Bundle queue between the lexer front end and the output serializer.
// Depends on sst_pkg.
module sst_fifo #(
  parameter int DEPTH = sst_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sst_pkg::bundle_t  wdata,
  input  logic              pop,
  output sst_pkg::bundle_t  rdata,
  output sst_pkg::q_stat_t  stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sst_pkg::bundle_t mem [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign rdata      = mem[rd_r];
  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    if (pop)  rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- src/sst_emit.sv -----
// Back end: unpacks queued bundles into single result beats on the output register.
// Depends on sst_pkg and shader_source_tokenizer_assert.svh.
`include "shader_source_tokenizer_assert.svh"

module sst_emit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sst_pkg::q_stat_t            q_stat,
  input  sst_pkg::bundle_t            q_rdata,
  output logic                        pop,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [sst_pkg::TDATA_W-1:0] out_tdata,
  output logic [sst_pkg::TUSER_W-1:0] out_tuser,
  output logic                        out_tlast
);

  sst_pkg::bundle_t            cur_r;
  logic                        cur_vld_r, cur_vld_nxt;
  logic [sst_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic [sst_pkg::CNT_W-1:0]   idx_ext, idx_inc;
  logic                        out_vld_r, out_vld_nxt;
  logic [sst_pkg::TDATA_W-1:0] tdata_r;
  logic [sst_pkg::TUSER_W-1:0] tuser_r;
  logic                        tlast_r;
  logic                        out_load, emit_now, fin;
  sst_pkg::res_t               sel;

  assign idx_ext  = sst_pkg::CNT_W'(idx_r);
  assign idx_inc  = idx_ext + 1'b1;
  assign out_load = !out_vld_r || out_tready;
  assign emit_now = cur_vld_r && out_load;
  assign fin      = emit_now && (idx_inc == cur_r.cnt);
  assign pop      = !q_stat.empty && (!cur_vld_r || fin);
  assign sel      = cur_r.res[idx_r];

  assign out_tvalid = out_vld_r;
  assign out_tdata  = tdata_r;
  assign out_tuser  = tuser_r;
  assign out_tlast  = tlast_r;

  always_comb begin
    cur_vld_nxt = cur_vld_r;
    idx_nxt     = idx_r;
    out_vld_nxt = out_vld_r;
    if (pop) begin
      cur_vld_nxt = 1'b1;
      idx_nxt     = '0;
    end else if (fin) begin
      cur_vld_nxt = 1'b0;
    end else if (emit_now) begin
      idx_nxt = idx_r + 1'b1;
    end
    if (out_load) out_vld_nxt = emit_now;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      idx_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
      idx_r     <= idx_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur_r <= q_rdata;
    if (emit_now) begin
      tdata_r <= {6'd0, sel.err, cur_r.col, cur_r.line, sel.data};
      tuser_r <= {sel.ttype, sel.kind};
      tlast_r <= fin;
    end
  end

  `SST_ASSERT_NOW(a_idx_in_range, cur_vld_r, idx_ext < cur_r.cnt, "result index past bundle size")
  `SST_ASSERT_NOW(a_pop_nonempty, pop, !q_stat.empty && q_rdata.cnt != '0, "popped empty bundle")
  `SST_ASSERT_NEXT(a_fin_tlast, fin, out_tvalid && out_tlast, "bundle end not flagged on output")

endmodule

// ----- src/shader_source_tokenizer.sv -----
// Top level of the shader source tokenizer: lexer front end, bundle queue, serializer.
// Depends on sst_pkg, sst_lexer, sst_fifo and sst_emit.
//
//   channel | dir | tdata                         | tuser               | tlast
//   in_     | in  | [7:0] in_byte                 | -                   | end_of_source
//   out_    | out | text, line, column, error     | item_kind, type     | last_result
//
// One source byte accepted per cycle while the queue has room; each byte yields 0 to 4 result beats.
// Results leave one per cycle while out_tready is high, so a byte with k results takes k output beats.
// A queue of QUEUE_DEPTH result bundles decouples input from output; input stalls when full.
// Reset is synchronous and active low; no clearing pass.
module shader_source_tokenizer #(
  parameter int QUEUE_DEPTH = sst_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] in_byte
  input  logic                        in_tlast,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [sst_pkg::TDATA_W-1:0] out_tdata,  // [7:0] text_byte, [23:8] line_number,
                                                  // [39:24] column_number, [41:40] error_code
  output logic [sst_pkg::TUSER_W-1:0] out_tuser,  // [0] item_kind, [3:1] token_type
  output logic                        out_tlast
);

  sst_pkg::q_stat_t q_stat;
  sst_pkg::bundle_t wbundle, rbundle;
  logic             push, pop;

  sst_lexer u_lexer (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .q_stat    (q_stat),
    .push      (push),
    .bundle    (wbundle)
  );

  sst_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (wbundle),
    .pop   (pop),
    .rdata (rbundle),
    .stat  (q_stat)
  );

  sst_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_rdata    (rbundle),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
